FILE: sv/phfe_pkg.sv
// shared types, constants and helpers for the packet header field extractor
// no dependencies

package phfe_pkg;

  localparam int LENGTH_BITS_DEF = 16;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86DD;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;

  // byte offsets and minimum lengths, all below 128
  localparam logic [6:0] ETH_HDR_BYTES = 7'd14;
  localparam logic [6:0] IPV4_MIN_LEN  = 7'd34;
  localparam logic [6:0] IPV6_MIN_LEN  = 7'd54;
  localparam logic [6:0] IPV6_L4_OFF   = 7'd54;
  localparam logic [6:0] TCP_HDR_BYTES = 7'd20;
  localparam logic [6:0] UDP_HDR_BYTES = 7'd8;

  localparam logic [1:0] DIR_INGRESS = 2'd1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [47:0] dest_mac;
    logic [47:0] source_mac;
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [1:0]  direction_tag;
    logic [15:0] frame_length;
    logic [63:0] source_addr_high;
    logic [63:0] source_addr_low;
    logic [63:0] dest_addr_high;
    logic [63:0] dest_addr_low;
  } record_t;

  // replace byte idx (0 = least significant) of a 64-bit word
  function automatic logic [63:0] put_byte64(input logic [63:0] w, input logic [7:0] b,
                                             input logic [2:0] idx);
    logic [63:0] r;
    r = w;
    r[{idx, 3'b000} +: 8] = b;
    return r;
  endfunction

endpackage

FILE: sv/phfe_in_stage.sv
// input register of the packet header field extractor
// depends on phfe_pkg

module phfe_in_stage import phfe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_item_t in_item,
  output logic     in_stall,
  input  logic     take,
  output logic     item_valid,
  output in_item_t item
);

  logic     valid_r, valid_nxt;
  in_item_t item_r;
  logic     load;

  assign in_stall   = valid_r && !take;
  assign load       = in_valid && !in_stall;
  assign valid_nxt  = load || (valid_r && !take);
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (load) begin
      item_r <= in_item;
    end
  end

endmodule

FILE: sv/phfe_parser.sv
// per-frame header state and the record built on the last byte
// depends on phfe_pkg

module phfe_parser import phfe_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  in_item_t   item,
  input  logic [1:0] direction,
  output logic       emit,
  output record_t    rec
);

  logic [LENGTH_BITS-1:0] cnt_r, len;
  logic [47:0] mac_dst_r, mac_dst_nxt, mac_src_r, mac_src_nxt;
  logic [15:0] etype_r, etype_nxt;
  logic [3:0]  ihl_r, ihl_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [63:0] src_hi_r, src_hi_nxt, src_lo_r, src_lo_nxt;
  logic [63:0] dst_hi_r, dst_hi_nxt, dst_lo_r, dst_lo_nxt;
  logic [31:0] ports_r, ports_nxt;

  logic [7:0]  b;
  logic [6:0]  p7, len7, off, need;
  logic        p_big, len_big, is_v4, is_v6, ip_ok, ports_ok;
  logic [2:0]  mac_idx;
  logic [3:0]  src_idx;
  logic [6:0]  port_idx;
  logic [32:0] len_ext;

  always_comb begin
    b         = item.data_byte;
    p7        = cnt_r[6:0];
    p_big     = |cnt_r[LENGTH_BITS-1:7];
    is_v4     = (etype_r == ETHERTYPE_IPV4);
    is_v6     = (etype_r == ETHERTYPE_IPV6);
    mac_dst_nxt = mac_dst_r;
    mac_src_nxt = mac_src_r;
    etype_nxt   = etype_r;
    ihl_nxt     = ihl_r;
    proto_nxt   = proto_r;
    src_hi_nxt  = src_hi_r;
    src_lo_nxt  = src_lo_r;
    dst_hi_nxt  = dst_hi_r;
    dst_lo_nxt  = dst_lo_r;
    ports_nxt   = ports_r;
    off         = 7'd0;
    mac_idx     = 3'd5 - p7[2:0];
    src_idx     = 4'd11 - p7[3:0];

    if (!p_big && p7 < 7'd6) begin
      mac_dst_nxt[{mac_idx, 3'b000} +: 8] = b;
    end else if (!p_big && p7 < 7'd12) begin
      mac_src_nxt[{src_idx[2:0], 3'b000} +: 8] = b;
    end else if (!p_big && p7 < ETH_HDR_BYTES) begin
      if (p7 == 7'd12) begin
        etype_nxt[15:8] = b;
      end else begin
        etype_nxt[7:0] = b;
      end
    end else if (is_v4) begin
      if (!p_big && p7 == 7'd14) begin
        ihl_nxt = b[3:0];
      end
      if (!p_big && p7 == 7'd23) begin
        proto_nxt = b;
      end
      if (!p_big && p7 >= 7'd26 && p7 <= 7'd29) begin
        src_lo_nxt = put_byte64(src_lo_r, b, 3'(7'd29 - p7));
      end
      if (!p_big && p7 >= 7'd30 && p7 <= 7'd33) begin
        dst_lo_nxt = put_byte64(dst_lo_r, b, 3'(7'd33 - p7));
      end
    end else if (is_v6) begin
      if (!p_big && p7 == 7'd20) begin
        proto_nxt = b;
      end
      if (!p_big && p7 >= 7'd22 && p7 <= 7'd29) begin
        src_hi_nxt = put_byte64(src_hi_r, b, 3'(7'd29 - p7));
      end
      if (!p_big && p7 >= 7'd30 && p7 <= 7'd37) begin
        src_lo_nxt = put_byte64(src_lo_r, b, 3'(7'd37 - p7));
      end
      if (!p_big && p7 >= 7'd38 && p7 <= 7'd45) begin
        dst_hi_nxt = put_byte64(dst_hi_r, b, 3'(7'd45 - p7));
      end
      if (!p_big && p7 >= 7'd46 && p7 <= 7'd53) begin
        dst_lo_nxt = put_byte64(dst_lo_r, b, 3'(7'd53 - p7));
      end
    end

    // transport header offset, using the ihl taken on this very byte
    if (is_v4) begin
      off = ETH_HDR_BYTES + {1'b0, ihl_nxt, 2'b00};
    end else if (is_v6) begin
      off = IPV6_L4_OFF;
    end
    port_idx = off + 7'd3 - p7;
    if ((is_v4 || is_v6) && !p_big && p7 >= ETH_HDR_BYTES && p7 >= off
        && p7 <= off + 7'd3) begin
      ports_nxt[{port_idx[1:0], 3'b000} +: 8] = b;
    end

    // saturating length including this byte
    len     = (&cnt_r) ? cnt_r : cnt_r + LENGTH_BITS'(1);
    len7    = len[6:0];
    len_big = |len[LENGTH_BITS-1:7];

    if (proto_nxt == PROTO_TCP) begin
      need = TCP_HDR_BYTES;
    end else if (proto_nxt == PROTO_UDP) begin
      need = UDP_HDR_BYTES;
    end else begin
      need = 7'd0;
    end
    if (is_v4) begin
      ip_ok = len_big || len7 >= IPV4_MIN_LEN;
    end else if (is_v6) begin
      ip_ok = len_big || len7 >= IPV6_MIN_LEN;
    end else begin
      ip_ok = 1'b0;
    end
    ports_ok = ip_ok && need != 7'd0
               && (len_big || {1'b0, len7} >= {1'b0, off} + {1'b0, need});

    len_ext = {{(33 - LENGTH_BITS){1'b0}}, len};
    emit    = step && item.last_byte && (len_big || len7 >= ETH_HDR_BYTES);

    rec.dest_mac         = mac_dst_nxt;
    rec.source_mac       = mac_src_nxt;
    rec.ether_type       = etype_nxt;
    rec.ip_protocol      = ip_ok ? proto_nxt : 8'd0;
    rec.source_port      = ports_ok ? ports_nxt[31:16] : 16'd0;
    rec.dest_port        = ports_ok ? ports_nxt[15:0] : 16'd0;
    rec.direction_tag    = direction;
    rec.frame_length     = (len_ext > 33'd65535) ? 16'hFFFF : len_ext[15:0];
    rec.source_addr_high = (ip_ok && is_v6) ? src_hi_nxt : 64'd0;
    rec.dest_addr_high   = (ip_ok && is_v6) ? dst_hi_nxt : 64'd0;
    if (ip_ok && is_v6) begin
      rec.source_addr_low = src_lo_nxt;
      rec.dest_addr_low   = dst_lo_nxt;
    end else if (ip_ok) begin
      rec.source_addr_low = {32'd0, src_lo_nxt[31:0]};
      rec.dest_addr_low   = {32'd0, dst_lo_nxt[31:0]};
    end else begin
      rec.source_addr_low = 64'd0;
      rec.dest_addr_low   = 64'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.last_byte)) begin
      cnt_r     <= '0;
      mac_dst_r <= '0;
      mac_src_r <= '0;
      etype_r   <= '0;
      ihl_r     <= '0;
      proto_r   <= '0;
      src_hi_r  <= '0;
      src_lo_r  <= '0;
      dst_hi_r  <= '0;
      dst_lo_r  <= '0;
      ports_r   <= '0;
    end else if (step) begin
      cnt_r     <= len;
      mac_dst_r <= mac_dst_nxt;
      mac_src_r <= mac_src_nxt;
      etype_r   <= etype_nxt;
      ihl_r     <= ihl_nxt;
      proto_r   <= proto_nxt;
      src_hi_r  <= src_hi_nxt;
      src_lo_r  <= src_lo_nxt;
      dst_hi_r  <= dst_hi_nxt;
      dst_lo_r  <= dst_lo_nxt;
      ports_r   <= ports_nxt;
    end
  end

  // frame state restarts after every last byte
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.last_byte |=> cnt_r == '0)
    else $error("byte count not cleared after last byte");

  // no record for a runt frame
  a_runt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> rec.frame_length >= 16'd14)
    else $error("record emitted for frame under ethernet header size");

endmodule

FILE: sv/phfe_out_stage.sv
// result register of the packet header field extractor
// depends on phfe_pkg

module phfe_out_stage import phfe_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  record_t rec,
  input  logic    out_stall,
  output logic    out_valid,
  output record_t out_rec,
  output logic    free
);

  logic    valid_r, valid_nxt;
  record_t rec_r;

  assign free      = !valid_r || !out_stall;
  assign valid_nxt = load || (valid_r && out_stall);
  assign out_valid = valid_r;
  assign out_rec   = rec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (load) begin
      rec_r <= rec;
    end
  end

endmodule

FILE: sv/packet_header_field_extractor.sv
// top level of the packet header field extractor (ethernet, ipv4/ipv6, tcp/udp)
// depends on phfe_pkg, phfe_in_stage, phfe_parser, phfe_out_stage

// Takes a frame one byte per transfer, wire order, with in_last_byte on the
// final byte, and on that byte hands out one record: both mac addresses, the
// ethertype, the ipv4 protocol or ipv6 next header, the ip addresses (ipv4 in
// the low 32 bits of the low words), tcp/udp ports when the whole transport
// header lies in the frame, the saturated byte count and the direction tag.
// Frames shorter than 14 bytes give no record. Sustained rate is one byte per
// cycle while no last byte waits for the result register: each byte goes
// through an input register, is parsed against the frame state, and a last
// byte writes the result register, which holds the record. Non-last bytes keep
// flowing while a record waits in the result register; only a last byte is
// held in the input register until the result register is free. The
// direction register is written through cfg_valid/cfg_ready (always ready)
// and resets to ingress; write it only between frames. vlan tags are not
// decoded and count as an unknown ethertype.

module packet_header_field_extractor import phfe_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // byte input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  // record output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [47:0] out_dest_mac,
  output logic [47:0] out_source_mac,
  output logic [15:0] out_ether_type,
  output logic [7:0]  out_ip_protocol,
  output logic [15:0] out_source_port,
  output logic [15:0] out_dest_port,
  output logic [1:0]  out_direction_tag,
  output logic [15:0] out_frame_length,
  output logic [63:0] out_source_addr_high,
  output logic [63:0] out_source_addr_low,
  output logic [63:0] out_dest_addr_high,
  output logic [63:0] out_dest_addr_low,
  // direction register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_direction_code
);

  in_item_t   in_item, item;
  logic       item_valid, step, emit, out_free;
  record_t    rec, out_rec;
  logic [1:0] direction_r;

  assign in_item.data_byte = in_data_byte;
  assign in_item.last_byte = in_last_byte;

  // a last byte needs room in the result register, other bytes never wait
  assign step      = item_valid && (!item.last_byte || out_free);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= DIR_INGRESS;
    end else if (cfg_valid && cfg_ready) begin
      direction_r <= cfg_direction_code;
    end
  end

  phfe_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .in_stall   (in_stall),
    .take       (step),
    .item_valid (item_valid),
    .item       (item)
  );

  phfe_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (item),
    .direction (direction_r),
    .emit      (emit),
    .rec       (rec)
  );

  phfe_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (emit),
    .rec       (rec),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_rec   (out_rec),
    .free      (out_free)
  );

  assign out_dest_mac         = out_rec.dest_mac;
  assign out_source_mac       = out_rec.source_mac;
  assign out_ether_type       = out_rec.ether_type;
  assign out_ip_protocol      = out_rec.ip_protocol;
  assign out_source_port      = out_rec.source_port;
  assign out_dest_port        = out_rec.dest_port;
  assign out_direction_tag    = out_rec.direction_tag;
  assign out_frame_length     = out_rec.frame_length;
  assign out_source_addr_high = out_rec.source_addr_high;
  assign out_source_addr_low  = out_rec.source_addr_low;
  assign out_dest_addr_high   = out_rec.dest_addr_high;
  assign out_dest_addr_low    = out_rec.dest_addr_low;

  // a new record never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> !(out_valid && out_stall))
    else $error("record overwrote an untaken record");

  // ports only come with a tcp or udp protocol
  a_ports_need_l4: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_source_port != 16'd0 || out_dest_port != 16'd0)
    |-> (out_ip_protocol == PROTO_TCP || out_ip_protocol == PROTO_UDP))
    else $error("ports reported without tcp or udp");

endmodule
